// ===== rtl/fdg_pkg.sv =====
`default_nettype none
package fdg_pkg;

   localparam int unsigned DIV_BITS_PER_STAGE = 4;
   localparam int unsigned DIV_STAGES = 7;
   localparam int unsigned DIV_QBITS = DIV_BITS_PER_STAGE * DIV_STAGES;
   localparam int unsigned DIV_LATENCY = DIV_STAGES + 3;
   localparam int unsigned MUL_LATENCY = 3;

   localparam logic [31:0] QNAN = 32'h7FC0_0000;
   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

   typedef logic signed [11:0] exp_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] word;
   } special_type;

   function automatic logic is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(input logic [31:0] v);
      return v[30:0] == 31'd0;
   endfunction

   function automatic exp_type eff_exp(input logic [7:0] e);
      return (e == 8'd0) ? exp_type'(12'sd1) : exp_type'({4'b0000, e});
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            n = 6'(47 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [31:0] round_pack(input logic sign, input exp_type bexp,
                                              input logic [47:0] sig);
      logic [47:0] s;
      logic [5:0]  sh;
      exp_type     amt;
      logic [7:0]  ef;
      logic [30:0] word;
      logic        lost;
      logic        up;
      s = sig;
      ef = bexp[7:0];
      lost = 1'b0;
      amt = 12'sd1 - bexp;
      if (bexp < 12'sd1) begin
         sh = (amt > 12'sd49) ? 6'd49 : amt[5:0];
         s = sig >> sh;
         lost = ((s << sh) != sig);
         ef = 8'd0;
      end
      up = s[23] & (lost | (|s[22:0]) | s[24]);
      word = {ef, s[46:24]} + 31'(up);
      if (bexp > 12'sd254) begin
         return {sign, 8'hFF, 23'd0};
      end
      return {sign, word};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/fdg_fmul.sv =====
`default_nettype none
module fdg_fmul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [31:0] x_value,
   input  wire logic [31:0] y_value,
   output logic             out_valid,
   output logic [31:0]      result
);
   import fdg_pkg::*;

   logic        v1_ff, v2_ff, v3_ff;
   logic [47:0] prod1_ff, sig2_ff;
   exp_type     exp1_ff, exp2_ff;
   logic        sign1_ff, sign2_ff;
   special_type spec1_ff, spec2_ff, spec_in;
   logic [31:0] res3_ff;
   logic [23:0] mx, my;
   logic        sign_in;
   logic [5:0]  lz;

   always_comb begin
      mx = {x_value[30:23] != 8'd0, x_value[22:0]};
      my = {y_value[30:23] != 8'd0, y_value[22:0]};
      sign_in = x_value[31] ^ y_value[31];
      spec_in = '{hit: 1'b0, word: 32'd0};
      if (is_nan(x_value) || is_nan(y_value) || (is_inf(x_value) && is_zero(y_value))
          || (is_zero(x_value) && is_inf(y_value))) begin
         spec_in = '{hit: 1'b1, word: QNAN};
      end else if (is_inf(x_value) || is_inf(y_value)) begin
         spec_in = '{hit: 1'b1, word: {sign_in, 8'hFF, 23'd0}};
      end else if (is_zero(x_value) || is_zero(y_value)) begin
         spec_in = '{hit: 1'b1, word: {sign_in, 31'd0}};
      end
   end

   assign lz = lzc48(prod1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff <= mx * my;
         exp1_ff  <= eff_exp(x_value[30:23]) + eff_exp(y_value[30:23]) - 12'sd126;
         sign1_ff <= sign_in;
         spec1_ff <= spec_in;
         sig2_ff  <= prod1_ff << lz;
         exp2_ff  <= exp1_ff - exp_type'({6'd0, lz});
         sign2_ff <= sign1_ff;
         spec2_ff <= spec1_ff;
         res3_ff  <= spec2_ff.hit ? spec2_ff.word : round_pack(sign2_ff, exp2_ff, sig2_ff);
      end
   end

   assign out_valid = v3_ff;
   assign result = res3_ff;
endmodule
`default_nettype wire

// ===== rtl/fdg_fdiv.sv =====
`default_nettype none
module fdg_fdiv (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [31:0] x_value,
   input  wire logic [31:0] y_value,
   output logic             out_valid,
   output logic [31:0]      result
);
   import fdg_pkg::*;

   logic                 v_ff    [DIV_STAGES+1];
   logic [24:0]          rem_ff  [DIV_STAGES+1];
   logic [DIV_QBITS-1:0] q_ff    [DIV_STAGES+1];
   logic [23:0]          den_ff  [DIV_STAGES+1];
   exp_type              exp_ff  [DIV_STAGES+1];
   logic                 sign_ff [DIV_STAGES+1];
   special_type          spec_ff [DIV_STAGES+1];

   logic        vn_ff, vr_ff;
   logic [47:0] sign_n_sig_ff;
   exp_type     exp_n_ff;
   logic        sign_n_ff;
   special_type spec_n_ff, spec_in;
   logic [31:0] res_ff;
   logic [23:0] mx, my, mxn, myn;
   logic [5:0]  lzx, lzy, lzq;
   logic [47:0] qsig;
   logic        sign_in;

   always_comb begin
      mx = {x_value[30:23] != 8'd0, x_value[22:0]};
      my = {y_value[30:23] != 8'd0, y_value[22:0]};
      lzx = lzc48({mx, 24'd0});
      lzy = lzc48({my, 24'd0});
      mxn = mx << lzx;
      myn = my << lzy;
      sign_in = x_value[31] ^ y_value[31];
      spec_in = '{hit: 1'b0, word: 32'd0};
      if (is_nan(x_value) || is_nan(y_value) || (is_inf(x_value) && is_inf(y_value))
          || (is_zero(x_value) && is_zero(y_value))) begin
         spec_in = '{hit: 1'b1, word: QNAN};
      end else if (is_inf(x_value) || is_zero(y_value)) begin
         spec_in = '{hit: 1'b1, word: {sign_in, 8'hFF, 23'd0}};
      end else if (is_zero(x_value) || is_inf(y_value)) begin
         spec_in = '{hit: 1'b1, word: {sign_in, 31'd0}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= {1'b0, mxn};
         q_ff[0]    <= '0;
         den_ff[0]  <= myn;
         exp_ff[0]  <= eff_exp(x_value[30:23]) - exp_type'({6'd0, lzx})
                       - eff_exp(y_value[30:23]) + exp_type'({6'd0, lzy}) + 12'sd127;
         sign_ff[0] <= sign_in;
         spec_ff[0] <= spec_in;
      end
   end

   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
      logic [24:0]          r;
      logic [DIV_QBITS-1:0] q;

      always_comb begin
         r = rem_ff[s-1];
         q = q_ff[s-1];
         for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
            if (r >= {1'b0, den_ff[s-1]}) begin
               r = r - {1'b0, den_ff[s-1]};
               q = {q[DIV_QBITS-2:0], 1'b1};
            end else begin
               q = {q[DIV_QBITS-2:0], 1'b0};
            end
            r = {r[23:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= r;
            q_ff[s]    <= q;
            den_ff[s]  <= den_ff[s-1];
            exp_ff[s]  <= exp_ff[s-1];
            sign_ff[s] <= sign_ff[s-1];
            spec_ff[s] <= spec_ff[s-1];
         end
      end
   end

   assign qsig = {q_ff[DIV_STAGES], rem_ff[DIV_STAGES] != 25'd0, 19'd0};
   assign lzq = lzc48(qsig);

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
         vr_ff <= 1'b0;
      end else if (en) begin
         vn_ff <= v_ff[DIV_STAGES];
         vr_ff <= vn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign_n_sig_ff <= qsig << lzq;
         exp_n_ff      <= exp_ff[DIV_STAGES] - exp_type'({6'd0, lzq});
         sign_n_ff     <= sign_ff[DIV_STAGES];
         spec_n_ff     <= spec_ff[DIV_STAGES];
         res_ff        <= spec_n_ff.hit ? spec_n_ff.word
                                        : round_pack(sign_n_ff, exp_n_ff, sign_n_sig_ff);
      end
   end

   assign out_valid = vr_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

// ===== rtl/float_divide_with_gradient.sv =====
// An accepted request flows through the multiplier stages, the divider stages and the output register to its result.
// Throughput: one request per cycle; three multiplier stages run ahead of two
// radix-2 dividers of ten stages each, seven of which retire four quotient bits.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset is synchronous and clears only the valid bits; data registers are not reset.
`default_nettype none
module float_divide_with_gradient (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_a_value,
   input  wire logic [31:0] req_b_value,
   input  wire logic [31:0] req_grad_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_main_result,
   output logic [31:0]      rsp_divisor_gradient,
   output logic             rsp_zero_divisor
);
   import fdg_pkg::*;

   localparam int unsigned SIDE_LATENCY = MUL_LATENCY + DIV_LATENCY;

   logic        en;
   logic        mv_num, mv_den, dv_main, dv_grad;
   logic [31:0] num, den, q_main, q_grad;
   logic [31:0] x_ff    [MUL_LATENCY];
   logic [31:0] b_ff    [MUL_LATENCY];
   logic        mode_ff [SIDE_LATENCY];
   logic        zb_ff   [SIDE_LATENCY];
   logic        rsp_valid_ff, rsp_zero_divisor_ff;
   logic [31:0] rsp_main_ff, rsp_grad_ff, grad_in;

   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   fdg_fmul u_mul_num (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .x_value(req_grad_value), .y_value(req_a_value),
      .out_valid(mv_num), .result(num)
   );

   fdg_fmul u_mul_den (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .x_value(req_b_value), .y_value(req_b_value),
      .out_valid(mv_den), .result(den)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= req_mode ? req_grad_value : req_a_value;
         b_ff[0]    <= req_b_value;
         mode_ff[0] <= req_mode;
         zb_ff[0]   <= req_b_value[30:0] == 31'd0;
         for (int i = 1; i < MUL_LATENCY; i++) begin
            x_ff[i] <= x_ff[i-1];
            b_ff[i] <= b_ff[i-1];
         end
         for (int i = 1; i < SIDE_LATENCY; i++) begin
            mode_ff[i] <= mode_ff[i-1];
            zb_ff[i]   <= zb_ff[i-1];
         end
      end
   end

   fdg_fdiv u_div_main (
      .clock(clock), .reset(reset), .en(en), .in_valid(mv_num),
      .x_value(x_ff[MUL_LATENCY-1]), .y_value(b_ff[MUL_LATENCY-1]),
      .out_valid(dv_main), .result(q_main)
   );

   fdg_fdiv u_div_grad (
      .clock(clock), .reset(reset), .en(en), .in_valid(mv_den),
      .x_value(num), .y_value(den),
      .out_valid(dv_grad), .result(q_grad)
   );

   always_comb begin
      grad_in = 32'd0;
      if (mode_ff[SIDE_LATENCY-1]) begin
         grad_in = is_nan(q_grad) ? QNAN : (q_grad ^ SIGN_MASK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_main;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_main_ff         <= q_main;
         rsp_grad_ff         <= grad_in;
         rsp_zero_divisor_ff <= zb_ff[SIDE_LATENCY-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_main_result = rsp_main_ff;
   assign rsp_divisor_gradient = rsp_grad_ff;
   assign rsp_zero_divisor = rsp_zero_divisor_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (dv_main == dv_grad) && (mv_num == mv_den))
      else $error("Divider pipelines lost lockstep.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dv_main) && $stable(mv_num))
      else $error("Pipeline advanced during a stall.");

   a_zero_div_special: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zero_divisor_ff |-> rsp_main_ff[30:23] == 8'hFF)
      else $error("Zero divisor did not give infinity or NaN.");
endmodule
`default_nettype wire
